/* design/permutation_cycle_decomposition_unit_assert.svh */
// Assertion macros for the permutation cycle decomposition unit.
`ifndef PERMUTATION_CYCLE_DECOMPOSITION_UNIT_ASSERT_SVH
`define PERMUTATION_CYCLE_DECOMPOSITION_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define PCD_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define PCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pcd_pkg.sv */
// Shared types and constants of the permutation cycle decomposition unit.
`default_nettype none

package pcd_pkg;

  // Width of the value field and of the result count fields.
  localparam int VALUE_W = 9;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // store the accepted beat
    logic scan_init;     // clear start position and result counters
    logic rd_vis_start;  // read the visited bit of the start position
    logic begin_cycle;   // mark start visited, read its image
    logic rd_vis_next;   // latch the next position, read its visited bit
    logic step;          // mark next visited, extend cycle, read its image
    logic close_cycle;   // count the cycle and advance the start position
    logic skip_start;    // start position already visited: advance it
    logic finish_ok;     // emit a valid result
    logic finish_bad;    // emit an invalid result
  } pcd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_bad;    // an overflow was seen or this beat overflows
    logic last_start;  // the start position is the last one
    logic vis_set;     // registered visited bit
    logic val_bad;     // registered image lies outside 1..n
    logic closes;      // registered image leads back to the start
  } pcd_stat_t;

endpackage

`default_nettype wire

/* design/pcd_datapath.sv */
// Datapath: permutation and visited memories, counters and result registers.
`default_nettype none

module pcd_datapath
  import pcd_pkg::*;
#(
  parameter int MAX_ELEMENTS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [VALUE_W-1:0] perm_value,
  input  wire pcd_cmd_t           cmd,
  output pcd_stat_t               stat,
  output logic                    done,
  output logic [VALUE_W-1:0]      cycle_count,
  output logic [VALUE_W-1:0]      max_cycle_len,
  output logic                    invalid
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int WW = (CW > VALUE_W) ? CW : VALUE_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);
  localparam logic [CW-1:0] ONE_CNT = CW'(1);

  // Memories, each with one write port and one registered read port.
  logic [VALUE_W-1:0] perm_mem [MAX_ELEMENTS];
  logic               vis_mem  [MAX_ELEMENTS];
  logic [VALUE_W-1:0] perm_rd;
  logic               vis_rd;

  logic [CW-1:0] load_count;
  logic          bad_seen;
  logic [CW-1:0] start_pos;
  logic [IW-1:0] next_pos;
  logic [CW-1:0] cycle_len;
  logic [CW-1:0] cycles;
  logic [CW-1:0] longest;

  logic          store_ok;
  logic [WW-1:0] val_w;
  logic [WW-1:0] val_dec;
  logic [IW-1:0] next_idx;
  logic [IW-1:0] start_idx;
  logic [IW-1:0] load_idx;
  logic [CW:0]   start_inc;
  logic [CW-1:0] cyc_inc;
  logic [CW-1:0] long_max;
  logic          vis_we;
  logic          vis_wd;
  logic [IW-1:0] vis_wa;
  logic [IW-1:0] vis_ra;
  logic [IW-1:0] perm_ra;

  // Decode of the registered image and of the counters.
  always_comb begin
    store_ok  = (load_count != MAX_CNT);
    val_w     = WW'(perm_rd);
    val_dec   = val_w - WW'(1);
    next_idx  = val_dec[IW-1:0];
    start_idx = start_pos[IW-1:0];
    load_idx  = load_count[IW-1:0];
    start_inc = {1'b0, start_pos} + (CW+1)'(1);
    cyc_inc   = cycles + ONE_CNT;
    long_max  = (cycle_len > longest) ? cycle_len : longest;

    stat.load_bad   = bad_seen | ~store_ok;
    stat.last_start = (start_inc == {1'b0, load_count});
    stat.vis_set    = vis_rd;
    stat.val_bad    = (perm_rd == '0) || (val_w > WW'(load_count));
    stat.closes     = (val_dec == WW'(start_pos));
  end

  // Memory port selection: the load clears visited bits, the walk sets them.
  always_comb begin
    vis_we  = (cmd.load & store_ok) | cmd.begin_cycle | cmd.step;
    vis_wd  = ~cmd.load;
    vis_wa  = cmd.load ? load_idx : (cmd.step ? next_pos : start_idx);
    vis_ra  = cmd.rd_vis_start ? start_idx : next_idx;
    perm_ra = cmd.step ? next_pos : start_idx;
  end

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      perm_mem[load_idx] <= perm_value;
    end
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    perm_rd <= perm_mem[perm_ra];
    vis_rd  <= vis_mem[vis_ra];
  end

  // Walk registers, which need no reset.
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      start_pos <= '0;
      cycles    <= '0;
      longest   <= '0;
    end
    if (cmd.begin_cycle) begin
      cycle_len <= ONE_CNT;
    end
    if (cmd.rd_vis_next) begin
      next_pos <= next_idx;
    end
    if (cmd.step) begin
      cycle_len <= cycle_len + ONE_CNT;
    end
    if (cmd.close_cycle) begin
      cycles    <= cyc_inc;
      longest   <= long_max;
      start_pos <= start_inc[CW-1:0];
    end
    if (cmd.skip_start) begin
      start_pos <= start_inc[CW-1:0];
    end
    if (cmd.finish_ok) begin
      invalid       <= 1'b0;
      cycle_count   <= VALUE_W'(cmd.close_cycle ? cyc_inc : cycles);
      max_cycle_len <= VALUE_W'(cmd.close_cycle ? long_max : longest);
    end
    if (cmd.finish_bad) begin
      invalid       <= 1'b1;
      cycle_count   <= '0;
      max_cycle_len <= '0;
    end
  end

  // Load control and the result strobe; a finish overrides a load.
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      bad_seen   <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= cmd.finish_ok | cmd.finish_bad;
      if (cmd.finish_ok || cmd.finish_bad) begin
        load_count <= '0;
        bad_seen   <= 1'b0;
      end else if (cmd.load) begin
        if (store_ok) begin
          load_count <= load_count + ONE_CNT;
        end else begin
          bad_seen <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/pcd_ctrl.sv */
// Controller: sequences the load and the cycle walk.
`default_nettype none

module pcd_ctrl
  import pcd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire logic      last_item,
  input  wire pcd_stat_t stat,
  output pcd_cmd_t       cmd,
  output logic           busy
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_PERM,
    S_VIS
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_item) begin
            if (stat.load_bad) begin
              cmd.finish_bad = 1'b1;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN_RD;
            end
          end
        end
      end
      S_SCAN_RD: begin
        cmd.rd_vis_start = 1'b1;
        state_next       = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (stat.vis_set) begin
          cmd.skip_start = 1'b1;
          if (stat.last_start) begin
            cmd.finish_ok = 1'b1;
            state_next    = S_LOAD;
          end else begin
            state_next = S_SCAN_RD;
          end
        end else begin
          cmd.begin_cycle = 1'b1;
          state_next      = S_PERM;
        end
      end
      S_PERM: begin
        if (stat.val_bad) begin
          cmd.finish_bad = 1'b1;
          state_next     = S_LOAD;
        end else if (stat.closes) begin
          cmd.close_cycle = 1'b1;
          if (stat.last_start) begin
            cmd.finish_ok = 1'b1;
            state_next    = S_LOAD;
          end else begin
            state_next = S_SCAN_RD;
          end
        end else begin
          cmd.rd_vis_next = 1'b1;
          state_next      = S_VIS;
        end
      end
      S_VIS: begin
        if (stat.vis_set) begin
          cmd.finish_bad = 1'b1;
          state_next     = S_LOAD;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_PERM;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // State and the registered busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_LOAD);
    end
  end

endmodule

`default_nettype wire

/* design/permutation_cycle_decomposition_unit.sv */
// Top level of the permutation cycle decomposition unit.
//
// The permutation is loaded one beat per clock while busy is low: a beat is
// taken on each edge with start high, and the beat with last_item high ends
// the load and fixes n. The block then raises busy and walks the cycles;
// a load of more than MAX_ELEMENTS beats gives an invalid result instead.
// Each start position is scanned (visited-bit read, check), each further
// element of a cycle takes an image read then a visited-bit read, and each
// cycle ends with the image read that closes it; an invalid permutation
// stops at the first fault. The walk is serial as each memory has a single
// registered read port. The result appears for one cycle with done high, on
// the edge where busy falls, or with busy low after an overflow; the receiver
// cannot stall it, so it must take it then. No clearing pass follows reset.
`default_nettype none
`include "permutation_cycle_decomposition_unit_assert.svh"

module permutation_cycle_decomposition_unit
  import pcd_pkg::*;
#(
  parameter int MAX_ELEMENTS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [VALUE_W-1:0] perm_value,
  input  wire logic               last_item,
  output logic                    done,
  output logic [VALUE_W-1:0]      cycle_count,
  output logic [VALUE_W-1:0]      max_cycle_len,
  output logic                    invalid
);

  pcd_cmd_t  cmd;
  pcd_stat_t stat;

  // Controller.
  pcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_item (last_item),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Datapath.
  pcd_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .perm_value    (perm_value),
    .cmd           (cmd),
    .stat          (stat),
    .done          (done),
    .cycle_count   (cycle_count),
    .max_cycle_len (max_cycle_len),
    .invalid       (invalid)
  );

  // A result beat is only shown once the walk is over.
  `PCD_ASSERT_IMPLIES(a_done_idle, done, !busy, "result shown while busy")
  // A beat that is not the last gives no result and keeps the block loading.
  `PCD_ASSERT_NEXT(a_no_early_result, start && !busy && !last_item, !done && !busy,
    "result or busy after a non-final beat")
  // Every finish command produces a result beat in the next cycle.
  `PCD_ASSERT_NEXT(a_finish_done, cmd.finish_ok || cmd.finish_bad, done,
    "finish without result beat")
  // An invalid result carries zero counts.
  `PCD_ASSERT_IMPLIES(a_invalid_zero, done && invalid,
    cycle_count == '0 && max_cycle_len == '0, "invalid result with counts")

endmodule

`default_nettype wire
